FILE: rtl/slrc_pkg.sv
package slrc_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW         = $clog2(DEPTH + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [CW-1:0]                t_count;

    typedef enum logic [1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_LOAD_C = 2'd2,
        FUNC_RUN    = 2'd3
    } t_func;

    typedef struct packed {
        t_func              func;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               has_value;
        logic               last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_M1_RD,
        ST_M1_CMP,
        ST_M2_RD,
        ST_M2_CMP,
        ST_OUT_RD,
        ST_OUT_CAP
    } t_state;

    function automatic t_data to_data(input logic signed [31:0] v);
        logic signed [63:0] ext;
        begin
            ext = 64'(v);
            return ext[DATA_WIDTH-1:0];
        end
    endfunction

    function automatic logic signed [31:0] to_result(input t_data d);
        logic signed [63:0] ext;
        begin
            ext = 64'(d);
            return ext[31:0];
        end
    endfunction

endpackage

FILE: rtl/sorted_list_remove_common.sv
// Loads may come back to back (func 0, 1, 2 append to list A, B, C; a load
// into a full list is dropped). A run command (func 3) computes A minus the
// multiset intersection of B and C and streams the surviving A elements, one
// per o_valid strobe, the final one flagged last; an empty result is one
// strobe with has_value 0. o_busy is high for the whole run: every merge step
// first reads the registered read port of each list memory and then compares,
// and the output walk reads each element of A and captures each survivor in a
// further step. The final strobe comes in the same cycle that o_busy falls.
// Results cannot be stalled: sample each strobe.
// After a run all lists are empty again.
module sorted_list_remove_common
    import slrc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_cmd,
    output logic o_busy,
    output logic o_valid,
    output t_out o_res
);

    t_data mem_a [DEPTH];
    t_data mem_b [DEPTH];
    t_data mem_c [DEPTH];
    t_data mem_com [DEPTH];

    t_state r_state, n_state;
    t_count r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b, r_cnt_c, n_cnt_c, r_ncom, n_ncom;
    t_count r_i, n_i, r_j, n_j;
    logic [DEPTH-1:0] r_keep, n_keep;
    t_data r_rd_a, r_rd_b, r_rd_c, r_rd_com;
    t_data r_pend, n_pend;
    logic r_pend_valid, n_pend_valid;
    logic r_valid, n_valid;
    t_out r_out, n_out;

    logic we_a, we_b, we_c, we_com;
    t_data wr_data;
    logic m1_go, m2_go, out_end, keep_cur;

    assign wr_data  = to_data(i_cmd.value);
    assign m1_go    = (r_i < r_cnt_b) && (r_j < r_cnt_c);
    assign m2_go    = (r_i < r_cnt_a) && (r_j < r_ncom);
    assign out_end  = (r_i >= r_cnt_a);
    assign keep_cur = r_keep[r_i[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (we_a) mem_a[r_cnt_a[AW-1:0]] <= wr_data;
        if (we_b) mem_b[r_cnt_b[AW-1:0]] <= wr_data;
        if (we_c) mem_c[r_cnt_c[AW-1:0]] <= wr_data;
        if (we_com) mem_com[r_ncom[AW-1:0]] <= r_rd_b;
        r_rd_a   <= mem_a[r_i[AW-1:0]];
        r_rd_b   <= mem_b[r_i[AW-1:0]];
        r_rd_c   <= mem_c[r_j[AW-1:0]];
        r_rd_com <= mem_com[r_j[AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_cmd.func == FUNC_RUN) n_state = ST_M1_RD;
            end
            ST_M1_RD:   n_state = m1_go ? ST_M1_CMP : ST_M2_RD;
            ST_M1_CMP:  n_state = ST_M1_RD;
            ST_M2_RD:   n_state = m2_go ? ST_M2_CMP : ST_OUT_RD;
            ST_M2_CMP:  n_state = ST_M2_RD;
            ST_OUT_RD: begin
                if (out_end) n_state = ST_IDLE;
                else if (keep_cur) n_state = ST_OUT_CAP;
            end
            ST_OUT_CAP: n_state = ST_OUT_RD;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_cnt_c      = r_cnt_c;
        n_ncom       = r_ncom;
        n_i          = r_i;
        n_j          = r_j;
        n_keep       = r_keep;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_valid      = 1'b0;
        n_out        = r_out;
        we_a         = 1'b0;
        we_b         = 1'b0;
        we_c         = 1'b0;
        we_com       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_cmd.func)
                        FUNC_LOAD_A: begin
                            if (r_cnt_a < CW'(DEPTH)) begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + CW'(1);
                            end
                        end
                        FUNC_LOAD_B: begin
                            if (r_cnt_b < CW'(DEPTH)) begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + CW'(1);
                            end
                        end
                        FUNC_LOAD_C: begin
                            if (r_cnt_c < CW'(DEPTH)) begin
                                we_c    = 1'b1;
                                n_cnt_c = r_cnt_c + CW'(1);
                            end
                        end
                        default: begin
                            n_i    = '0;
                            n_j    = '0;
                            n_ncom = '0;
                        end
                    endcase
                end
            end
            ST_M1_RD: begin
                if (!m1_go) begin
                    n_i = '0;
                    n_j = '0;
                end
            end
            ST_M1_CMP: begin
                if (r_rd_c < r_rd_b) begin
                    n_j = r_j + CW'(1);
                end else if (r_rd_b < r_rd_c) begin
                    n_i = r_i + CW'(1);
                end else begin
                    if (r_ncom < CW'(DEPTH)) begin
                        we_com = 1'b1;
                        n_ncom = r_ncom + CW'(1);
                    end
                    n_i = r_i + CW'(1);
                    n_j = r_j + CW'(1);
                end
            end
            ST_M2_RD: begin
                if (!m2_go) begin
                    n_i          = '0;
                    n_pend_valid = 1'b0;
                end
            end
            ST_M2_CMP: begin
                if (r_rd_a < r_rd_com) begin
                    n_i = r_i + CW'(1);
                end else if (r_rd_com < r_rd_a) begin
                    n_j = r_j + CW'(1);
                end else begin
                    n_keep[r_i[AW-1:0]] = 1'b0;
                    n_i = r_i + CW'(1);
                    n_j = r_j + CW'(1);
                end
            end
            ST_OUT_RD: begin
                if (out_end) begin
                    n_valid = 1'b1;
                    n_out.last = 1'b1;
                    if (r_pend_valid) begin
                        n_out.result_value = to_result(r_pend);
                        n_out.has_value    = 1'b1;
                    end else begin
                        n_out.result_value = '0;
                        n_out.has_value    = 1'b0;
                    end
                    n_cnt_a = '0;
                    n_cnt_b = '0;
                    n_cnt_c = '0;
                    n_keep  = '1;
                end else if (!keep_cur) begin
                    n_i = r_i + CW'(1);
                end
            end
            ST_OUT_CAP: begin
                if (r_pend_valid) begin
                    n_valid            = 1'b1;
                    n_out.result_value = to_result(r_pend);
                    n_out.has_value    = 1'b1;
                    n_out.last         = 1'b0;
                end
                n_pend       = r_rd_a;
                n_pend_valid = 1'b1;
                n_i          = r_i + CW'(1);
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_cnt_c      <= '0;
            r_ncom       <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_keep       <= '1;
            r_pend_valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_cnt_c      <= n_cnt_c;
            r_ncom       <= n_ncom;
            r_i          <= n_i;
            r_j          <= n_j;
            r_keep       <= n_keep;
            r_pend_valid <= n_pend_valid;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_out;

endmodule

FILE: rtl/slrc_chk.sv
module slrc_chk
    import slrc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input t_in  i_cmd,
    input logic o_busy,
    input logic o_valid,
    input t_out o_res
);

    // run transaction keeps the block busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd.func == FUNC_RUN) |=> o_busy)
        else $error("run not started");

    // load transaction completes without leaving the block busy
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd.func != FUNC_RUN) |=> !o_busy)
        else $error("load left block busy");

    // more results follow a result that is not last
    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.last) |=> (o_busy || o_valid))
        else $error("run ended without last");

    // empty marker is last and zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.has_value) |-> (o_res.last && o_res.result_value == 32'sd0))
        else $error("bad empty result");

endmodule

bind sorted_list_remove_common slrc_chk u_slrc_chk (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import slrc_pkg::*;

    typedef struct packed {
        t_in        cmd;
        logic [6:0] idle_pct;
        logic       drain;
    } t_pending;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_cmd   = '0;
    logic o_busy;
    logic o_valid;
    t_out o_res;

    sorted_list_remove_common dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pending cmd_q[$];
    t_out     survivor_q[$];
    t_out     want;
    int       mismatch_cnt = 0;
    int       sender_idle_pct = 0;
    bit       drain_next = 1'b0;
    int       phase_items = 0;
    int       phase_runs = 0;

    // list state of the predictor
    t_data list_a[DEPTH];
    t_data list_b[DEPTH];
    t_data list_c[DEPTH];
    t_data common_vals[DEPTH];
    bit    keep_mark[DEPTH];
    int    cnt_a, cnt_b, cnt_c;

    task automatic clear_lists();
        int k;
        begin
            cnt_a = 0;
            cnt_b = 0;
            cnt_c = 0;
            for (k = 0; k < DEPTH; k++) keep_mark[k] = 1'b1;
        end
    endtask

    task automatic run_remove_common();
        int   i, j, n_common, n_keep, k;
        t_out r;
        begin
            i = 0;
            j = 0;
            n_common = 0;
            while (i < cnt_b && j < cnt_c) begin
                if (list_c[j] < list_b[i]) begin
                    j++;
                end else if (list_b[i] < list_c[j]) begin
                    i++;
                end else begin
                    if (n_common < DEPTH) begin
                        common_vals[n_common] = list_b[i];
                        n_common++;
                    end
                    i++;
                    j++;
                end
            end
            i = 0;
            j = 0;
            while (i < cnt_a && j < n_common) begin
                if (list_a[i] < common_vals[j]) begin
                    i++;
                end else if (common_vals[j] < list_a[i]) begin
                    j++;
                end else begin
                    keep_mark[i] = 1'b0;
                    i++;
                    j++;
                end
            end
            n_keep = 0;
            for (i = 0; i < cnt_a; i++) if (keep_mark[i]) n_keep++;
            k = 0;
            for (i = 0; i < cnt_a; i++) begin
                if (keep_mark[i]) begin
                    r.result_value = list_a[i];
                    r.has_value    = 1'b1;
                    r.last         = (k == n_keep - 1);
                    survivor_q.push_back(r);
                    k++;
                end
            end
            if (n_keep == 0) begin
                r      = '0;
                r.last = 1'b1;
                survivor_q.push_back(r);
            end
            clear_lists();
        end
    endtask

    task automatic apply_cmd(input t_in cmd);
        t_data d;
        begin
            d = cmd.value;
            case (cmd.func)
                FUNC_LOAD_A: begin
                    if (cnt_a < DEPTH) begin
                        list_a[cnt_a] = d;
                        cnt_a++;
                    end
                end
                FUNC_LOAD_B: begin
                    if (cnt_b < DEPTH) begin
                        list_b[cnt_b] = d;
                        cnt_b++;
                    end
                end
                FUNC_LOAD_C: begin
                    if (cnt_c < DEPTH) begin
                        list_c[cnt_c] = d;
                        cnt_c++;
                    end
                end
                FUNC_RUN: begin
                    run_remove_common();
                end
            endcase
        end
    endtask

    task automatic push_cmd(input t_func f, input logic signed [31:0] v);
        t_pending p;
        begin
            p.cmd.func  = f;
            p.cmd.value = v;
            p.idle_pct  = 7'(sender_idle_pct);
            p.drain     = drain_next;
            drain_next  = 1'b0;
            cmd_q.push_back(p);
            phase_items++;
            if (f == FUNC_RUN) phase_runs++;
        end
    endtask

    task automatic load_full_list(input t_func f, input int mult, input int div);
        int k;
        begin
            for (k = 0; k < DEPTH + 2; k++) begin
                if (k < DEPTH) push_cmd(f, k * mult / div);
                else push_cmd(f, -7);
            end
        end
    endtask

    task automatic gen_sequence();
        int     kind, mode, l, k, cur, broken, n_noise;
        longint pool[8];
        int     idx[24];
        int     n[3];
        int     pos[3];
        begin
            kind = $urandom_range(0, 9);
            if (kind >= 8) begin
                n_noise = $urandom_range(1, 8);
                for (k = 0; k < n_noise; k++)
                    push_cmd(t_func'($urandom_range(0, 3)), $urandom);
                push_cmd(FUNC_RUN, $urandom);
            end else begin
                mode = $urandom_range(0, 2);
                if (mode == 0) begin
                    pool[0] = $urandom_range(0, 40) - 20;
                    for (k = 1; k < 8; k++) pool[k] = pool[k-1] + $urandom_range(1, 2);
                end else if (mode == 1) begin
                    pool[0] = longint'($signed($urandom));
                    for (k = 1; k < 8; k++) pool[k] = pool[k-1] + $urandom_range(1, 1000);
                    if (pool[7] > 64'sd2147483647) begin
                        cur = pool[7] - 64'sd2147483647;
                        for (k = 0; k < 8; k++) pool[k] = pool[k] - cur;
                    end
                end else begin
                    pool[0] = -64'sd2147483648;
                    pool[1] = -64'sd2147483647;
                    pool[2] = -2;
                    pool[3] = -1;
                    pool[4] = 0;
                    pool[5] = 1;
                    pool[6] = 64'sd2147483646;
                    pool[7] = 64'sd2147483647;
                end
                broken = (kind == 7) ? $urandom_range(0, 2) : -1;
                for (l = 0; l < 3; l++) begin
                    n[l] = $urandom_range(0, 6);
                    pos[l] = 0;
                    cur = $urandom_range(0, 2);
                    for (k = 0; k < n[l]; k++) begin
                        if (l == broken) begin
                            idx[l*8+k] = $urandom_range(0, 7);
                        end else begin
                            idx[l*8+k] = cur;
                            cur = cur + $urandom_range(0, 2);
                            if (cur > 7) cur = 7;
                        end
                    end
                end
                while (pos[0] < n[0] || pos[1] < n[1] || pos[2] < n[2]) begin
                    l = $urandom_range(0, 2);
                    if (pos[l] < n[l]) begin
                        push_cmd(t_func'(l), pool[idx[l*8+pos[l]]][31:0]);
                        pos[l]++;
                    end
                end
                push_cmd(FUNC_RUN, $urandom);
            end
        end
    endtask

    task automatic gen_phase();
        begin
            phase_items = 0;
            phase_runs = 0;
            while (phase_items < 8 || phase_runs < 1) gen_sequence();
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cmd   <= '0;
        end else begin
            if (i_start && !o_busy) apply_cmd(i_cmd);
            if (i_start && o_busy) begin
                i_start <= 1'b1;
            end else if (cmd_q.size() != 0
                         && !(cmd_q[0].drain && (survivor_q.size() != 0 || o_valid || o_busy))
                         && $urandom_range(0, 99) >= cmd_q[0].idle_pct) begin
                i_start <= 1'b1;
                i_cmd   <= cmd_q[0].cmd;
                void'(cmd_q.pop_front());
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (survivor_q.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected transaction: value %0d has_value %0b last %0b",
                             o_res.result_value, o_res.has_value, o_res.last);
                mismatch_cnt++;
            end else begin
                want = survivor_q.pop_front();
                if (o_res.result_value !== want.result_value
                    || o_res.has_value !== want.has_value
                    || o_res.last !== want.last) begin
                    if (mismatch_cnt < 10)
                        $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                 want.result_value, want.has_value, want.last,
                                 o_res.result_value, o_res.has_value, o_res.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        clear_lists();
        sender_idle_pct = 8;

        push_cmd(FUNC_RUN, 0);
        push_cmd(FUNC_LOAD_A, 32'sh8000_0000);
        push_cmd(FUNC_LOAD_A, 32'sh7fff_ffff);
        push_cmd(FUNC_RUN, 32'sh7fff_ffff);
        push_cmd(FUNC_LOAD_A, -5);
        push_cmd(FUNC_LOAD_B, 0);
        push_cmd(FUNC_LOAD_A, 0);
        push_cmd(FUNC_LOAD_C, 0);
        push_cmd(FUNC_LOAD_A, 0);
        push_cmd(FUNC_LOAD_B, 0);
        push_cmd(FUNC_LOAD_C, 7);
        push_cmd(FUNC_LOAD_A, 7);
        push_cmd(FUNC_LOAD_B, 7);
        push_cmd(FUNC_LOAD_C, 7);
        push_cmd(FUNC_RUN, 32'sh8000_0000);
        push_cmd(FUNC_LOAD_A, 3);
        push_cmd(FUNC_LOAD_B, 3);
        push_cmd(FUNC_LOAD_C, 3);
        push_cmd(FUNC_RUN, -1);
        push_cmd(FUNC_LOAD_A, 1);
        push_cmd(FUNC_LOAD_B, 2);
        push_cmd(FUNC_LOAD_C, 2);
        push_cmd(FUNC_RUN, 0);

        gen_phase();
        sender_idle_pct = 76;
        drain_next = 1'b1;
        gen_phase();
        sender_idle_pct = 0;
        drain_next = 1'b1;
        gen_phase();

        drain_next = 1'b1;
        load_full_list(FUNC_LOAD_A, 1, 1);
        push_cmd(FUNC_LOAD_B, 2);
        push_cmd(FUNC_LOAD_B, 4);
        push_cmd(FUNC_LOAD_B, 63);
        push_cmd(FUNC_LOAD_C, 4);
        push_cmd(FUNC_LOAD_C, 5);
        push_cmd(FUNC_LOAD_C, 63);
        push_cmd(FUNC_RUN, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || i_start) @(negedge i_clk);
        while (survivor_q.size() != 0) @(negedge i_clk);
        repeat (1000) @(negedge i_clk);
        if (mismatch_cnt == 0 && survivor_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
